@@ src/bsm3_pkg.sv @@
// Shared types, constants and helper functions of the 3x3 RGB box smoothing block.
// Used by bsm3_avg and box_smooth_3x3_rgb_top; depends on nothing else.
package bsm3_pkg;

  // Image geometry
  localparam int MAX_SIDE   = 1024;
  localparam int POS_W      = $clog2(MAX_SIDE);
  localparam int SIDE_W     = POS_W + 1;
  localparam int CFG_SIDE_W = 11;
  localparam int OUT_POS_W  = 10;
  localparam logic [CFG_SIDE_W-1:0] SIDE_RESET = 11'd1024;

  // Pixel and arithmetic widths
  localparam int CHAN_W  = 16;
  localparam int SUM_W   = 20;
  localparam int CNT_W   = 4;
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W = RECIP_SHIFT + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;

  // Reciprocals scaled by 2**RECIP_SHIFT, exact for every dividend below 2**SUM_W
  localparam logic [RECIP_W-1:0] RECIP_3 = 25'd5592406;
  localparam logic [RECIP_W-1:0] RECIP_9 = 25'd1864136;

  // Neighbor counts
  localparam logic [CNT_W-1:0] N_FULL   = 4'd9;
  localparam logic [CNT_W-1:0] N_EDGE   = 4'd6;
  localparam logic [CNT_W-1:0] N_CORNER = 4'd4;
  localparam logic [CNT_W-1:0] N_THREE  = 4'd3;
  localparam logic [CNT_W-1:0] N_TWO    = 4'd2;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_IMAGE_SIDE = 1'b0;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_t;

  // Window as [column][row]: column 0 is c-2, row 0 is r-2
  typedef pix_t [2:0][2:0] grid_t;

  // One result request from the item stage to the averaging pipeline
  typedef struct packed {
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
    logic [1:0]       rlo;
    logic [1:0]       clo;
  } req_t;

  typedef struct packed {
    logic [CHAN_W-1:0]    red;
    logic [CHAN_W-1:0]    green;
    logic [CHAN_W-1:0]    blue;
    logic [OUT_POS_W-1:0] row;
    logic [OUT_POS_W-1:0] col;
    logic                 last;
  } res_t;

  typedef struct packed {
    logic [RECIP_W-1:0] m;
    logic               halve;
  } div_t;

  // Clamp the configured side to 1..MAX_SIDE
  function automatic logic [SIDE_W-1:0] side_eff(input logic [CFG_SIDE_W-1:0] cfg);
    logic [SIDE_W-1:0] s;
    if (cfg == '0) begin
      s = SIDE_W'(1);
    end else if (int'(cfg) > MAX_SIDE) begin
      s = SIDE_W'(MAX_SIDE);
    end else begin
      s = SIDE_W'(cfg);
    end
    return s;
  endfunction

  // Reciprocal and pre-halving for a neighbor count; six is halved, then divided by three
  function automatic div_t div_of(input logic [CNT_W-1:0] n);
    div_t d;
    d.halve = 1'b0;
    case (n)
      N_FULL:   d.m = RECIP_9;
      N_EDGE: begin
        d.m     = RECIP_3;
        d.halve = 1'b1;
      end
      N_THREE:  d.m = RECIP_3;
      N_CORNER: d.m = RECIP_W'(1) << (RECIP_SHIFT - 2);
      N_TWO:    d.m = RECIP_W'(1) << (RECIP_SHIFT - 1);
      default:  d.m = RECIP_W'(1) << RECIP_SHIFT;
    endcase
    return d;
  endfunction

endpackage

@@ src/box_smooth_3x3_rgb_top.sv @@
// Top level of the 3x3 RGB box smoothing block: config port, positions, line stores,
// window and result sequencing. Depends on bsm3_pkg and bsm3_avg.
//
// Usage: pixels of a square image of side image_side come in raster order on the
// input channel (in_valid_i / in_stall_o), one item per pixel. Each smoothed pixel
// leaves on the output channel (out_valid_o / out_stall_i) once its last neighbor
// has arrived, with its row, column and a flag on the last result of that input.
// A result goes from the item stage through the sum stage into the output register;
// further results follow one per cycle while the output does not stall.
// Throughput: one item per cycle while the output does not stall. An item that completes
// several results (up to four, at the right column and on the bottom row) stalls the
// input until the averaging pipeline, taking one result per cycle, has taken them all.
// Line stores are two read-first RAMs of MAX_SIDE entries, read and written at the
// item's column on acceptance; rows alternate between them.
// Reset: positions return to row 0, column 0, image_side to 1024, the window to
// zero; the line stores are not cleared and need no clearing pass. Writing
// image_side restarts the frame.
// When the receiver stalls, the output register holds its result and the stages
// behind it fill and then stall the input.
module box_smooth_3x3_rgb_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bsm3_pkg::ADDR_W-1:0]   paddr,
  input  logic [bsm3_pkg::DATA_W-1:0]   pwdata,
  output logic [bsm3_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  // Pixel items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [bsm3_pkg::CHAN_W-1:0]   in_red_i,
  input  logic [bsm3_pkg::CHAN_W-1:0]   in_green_i,
  input  logic [bsm3_pkg::CHAN_W-1:0]   in_blue_i,
  // Smoothed items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [bsm3_pkg::CHAN_W-1:0]   out_red_o,
  output logic [bsm3_pkg::CHAN_W-1:0]   out_green_o,
  output logic [bsm3_pkg::CHAN_W-1:0]   out_blue_o,
  output logic [bsm3_pkg::OUT_POS_W-1:0] out_row_o,
  output logic [bsm3_pkg::OUT_POS_W-1:0] out_col_o,
  output logic                          last_of_run_o
);

  // Configuration and position
  logic [bsm3_pkg::CFG_SIDE_W-1:0] side_cfg_q;
  logic [bsm3_pkg::SIDE_W-1:0]     side, side_m1;
  logic                            cfg_wr;
  logic [bsm3_pkg::POS_W-1:0]      pos_r_q, pos_c_q, pos_r_d, pos_c_d;
  logic [bsm3_pkg::POS_W-1:0]      cur_r, cur_c;
  logic [bsm3_pkg::SIDE_W-1:0]     r1, c1;
  logic                            in_acc;
  bsm3_pkg::pix_t                  pix;

  // Line stores
  bsm3_pkg::pix_t                  line0_mem [bsm3_pkg::MAX_SIDE];
  bsm3_pkg::pix_t                  line1_mem [bsm3_pkg::MAX_SIDE];
  bsm3_pkg::pix_t                  rd0_q, rd1_q;
  bsm3_pkg::pix_t                  older, newer;

  // Item stage
  logic                            a_valid_q;
  logic [bsm3_pkg::POS_W-1:0]      a_r_q, a_c_q;
  bsm3_pkg::pix_t                  a_pix_q;
  logic                            ri_q, ci_q;
  logic                            r_ge1, r_ge2, r_last, c_ge1, c_ge2, c_last;
  logic [1:0]                      nr, nc;
  logic                            has_res, last_res, a_done;
  logic [bsm3_pkg::POS_W-1:0]      row_sel, col_sel;
  logic [1:0]                      rlo_sel, clo_sel;
  bsm3_pkg::pix_t [5:0]            win_q;
  bsm3_pkg::grid_t                 grid;
  bsm3_pkg::req_t                  req;
  logic                            req_valid, req_ready, req_acc;
  bsm3_pkg::res_t                  res;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[bsm3_pkg::ADDR_W-1] == bsm3_pkg::REG_IMAGE_SIDE);
  assign prdata = (paddr[bsm3_pkg::ADDR_W-1] == bsm3_pkg::REG_IMAGE_SIDE)
                  ? bsm3_pkg::DATA_W'(side_cfg_q) : '0;

  assign side    = bsm3_pkg::side_eff(side_cfg_q);
  assign side_m1 = side - bsm3_pkg::SIDE_W'(1);

  assign pix    = '{red: in_red_i, green: in_green_i, blue: in_blue_i};
  assign in_acc = in_valid_i && !in_stall_o;

  // Wrap a stale position and step to the next pixel
  always_comb begin
    if ({1'b0, pos_r_q} >= side || {1'b0, pos_c_q} >= side) begin
      cur_r = '0;
      cur_c = '0;
    end else begin
      cur_r = pos_r_q;
      cur_c = pos_c_q;
    end
    c1 = {1'b0, cur_c} + bsm3_pkg::SIDE_W'(1);
    r1 = {1'b0, cur_r} + bsm3_pkg::SIDE_W'(1);
    if (c1 >= side) begin
      pos_c_d = '0;
      pos_r_d = (r1 >= side) ? '0 : r1[bsm3_pkg::POS_W-1:0];
    end else begin
      pos_c_d = c1[bsm3_pkg::POS_W-1:0];
      pos_r_d = cur_r;
    end
  end

  // Hold configuration and position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_cfg_q <= bsm3_pkg::SIDE_RESET;
      pos_r_q    <= '0;
      pos_c_q    <= '0;
    end else if (cfg_wr) begin
      side_cfg_q <= pwdata[bsm3_pkg::CFG_SIDE_W-1:0];
      pos_r_q    <= '0;
      pos_c_q    <= '0;
    end else if (in_acc) begin
      pos_r_q <= pos_r_d;
      pos_c_q <= pos_c_d;
    end
  end

  // Read both lines at the column, write the pixel into the line of this row's parity
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rd0_q <= line0_mem[cur_c];
      rd1_q <= line1_mem[cur_c];
      if (!cur_r[0]) begin
        line0_mem[cur_c] <= pix;
      end else begin
        line1_mem[cur_c] <= pix;
      end
    end
  end

  // Results of this item: rows and columns of pixels it completes
  always_comb begin
    r_ge1  = a_r_q != '0;
    r_ge2  = a_r_q > bsm3_pkg::POS_W'(1);
    r_last = {1'b0, a_r_q} == side_m1;
    c_ge1  = a_c_q != '0;
    c_ge2  = a_c_q > bsm3_pkg::POS_W'(1);
    c_last = {1'b0, a_c_q} == side_m1;
    nr     = {1'b0, r_ge1} + {1'b0, r_last};
    nc     = {1'b0, c_ge1} + {1'b0, c_last};

    if (r_ge1 && !ri_q) begin
      row_sel = a_r_q - bsm3_pkg::POS_W'(1);
      rlo_sel = r_ge2 ? 2'd0 : 2'd1;
    end else begin
      row_sel = a_r_q;
      rlo_sel = r_ge1 ? 2'd1 : 2'd2;
    end
    if (c_ge1 && !ci_q) begin
      col_sel = a_c_q - bsm3_pkg::POS_W'(1);
      clo_sel = c_ge2 ? 2'd0 : 2'd1;
    end else begin
      col_sel = a_c_q;
      clo_sel = c_ge1 ? 2'd1 : 2'd2;
    end

    has_res  = (nr != '0) && (nc != '0);
    last_res = ({1'b0, ri_q} == nr - 2'd1) && ({1'b0, ci_q} == nc - 2'd1);
  end

  assign req_valid  = a_valid_q && has_res;
  assign req_acc    = req_valid && req_ready;
  assign a_done     = a_valid_q && (!has_res || (req_ready && last_res));
  assign in_stall_o = a_valid_q && !a_done;

  assign req = '{row: row_sel, col: col_sel, last: last_res, rlo: rlo_sel, clo: clo_sel};

  // Assemble the window: lines above are gated by the row
  assign older = a_r_q[0] ? rd1_q : rd0_q;
  assign newer = a_r_q[0] ? rd0_q : rd1_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      grid[0][k] = win_q[3 + k];
      grid[1][k] = win_q[k];
    end
    grid[2][0] = r_ge2 ? older : '0;
    grid[2][1] = r_ge1 ? newer : '0;
    grid[2][2] = a_pix_q;
  end

  // Item stage control, result sequencing and window shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      ri_q      <= 1'b0;
      ci_q      <= 1'b0;
      win_q     <= '0;
    end else begin
      if (in_acc) begin
        a_valid_q <= 1'b1;
      end else if (a_done) begin
        a_valid_q <= 1'b0;
      end
      if (req_acc) begin
        if (last_res) begin
          ri_q <= 1'b0;
          ci_q <= 1'b0;
        end else if (ci_q || nc == 2'd1) begin
          ci_q <= 1'b0;
          ri_q <= 1'b1;
        end else begin
          ci_q <= 1'b1;
        end
      end
      if (a_done) begin
        for (int k = 0; k < 3; k++) begin
          win_q[3 + k] <= win_q[k];
          win_q[k]     <= grid[2][k];
        end
      end
    end
  end

  // Capture the item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_r_q   <= cur_r;
      a_c_q   <= cur_c;
      a_pix_q <= pix;
    end
  end

  bsm3_avg u_avg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid),
    .req_ready_o (req_ready),
    .req_i       (req),
    .grid_i      (grid),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign out_red_o     = res.red;
  assign out_green_o   = res.green;
  assign out_blue_o    = res.blue;
  assign out_row_o     = res.row;
  assign out_col_o     = res.col;
  assign last_of_run_o = res.last;

`ifndef NO_ASSERTIONS
  // The position never leaves the configured image
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_r_q} < side && {1'b0, pos_c_q} < side)
    else $error("position outside image");

  // Result indexes stay within the rows and columns this item completes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && has_res |-> (!ri_q || nr == 2'd2) && (!ci_q || nc == 2'd2))
    else $error("result index out of range");

  // An unfinished item keeps its position until its last result is issued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !a_done |=> a_valid_q && $stable(a_r_q) && $stable(a_c_q))
    else $error("item left before its last result");

  // Indexes are back at zero when a new item arrives
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !ri_q && !ci_q)
    else $error("result index not cleared for new item");
`endif

endmodule

@@ src/bsm3_avg.sv @@
// Averaging pipeline: masked 3x3 sums, then division by the neighbor count.
// Depends on bsm3_pkg; ends in the output register of the result channel.
module bsm3_avg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           req_valid_i,
  output logic           req_ready_o,
  input  bsm3_pkg::req_t req_i,
  input  bsm3_pkg::grid_t grid_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output bsm3_pkg::res_t res_o
);

  // Sum stage
  logic                        b_valid_q;
  logic [bsm3_pkg::SUM_W-1:0]  sum_r_d, sum_g_d, sum_b_d;
  logic [bsm3_pkg::SUM_W-1:0]  sum_r_q, sum_g_q, sum_b_q;
  logic [bsm3_pkg::CNT_W-1:0]  cnt_d;
  bsm3_pkg::div_t              div_q;
  bsm3_pkg::req_t              b_req_q;
  logic                        b_ready, b_load;

  // Output stage
  logic                        c_valid_q, c_ready, c_load;
  bsm3_pkg::res_t              res_d, res_q;
  logic [bsm3_pkg::SUM_W-1:0]  x_r, x_g, x_b;
  logic [bsm3_pkg::PROD_W-1:0] p_r, p_g, p_b;

  assign c_ready     = !c_valid_q || !out_stall_i;
  assign b_ready     = !b_valid_q || c_ready;
  assign b_load      = req_valid_i && b_ready;
  assign c_load      = b_valid_q && c_ready;
  assign req_ready_o = b_ready;

  // Sum the in-bounds part of the window per channel
  always_comb begin
    sum_r_d = '0;
    sum_g_d = '0;
    sum_b_d = '0;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        if (i >= int'(req_i.clo) && k >= int'(req_i.rlo)) begin
          sum_r_d = sum_r_d + bsm3_pkg::SUM_W'(grid_i[i][k].red);
          sum_g_d = sum_g_d + bsm3_pkg::SUM_W'(grid_i[i][k].green);
          sum_b_d = sum_b_d + bsm3_pkg::SUM_W'(grid_i[i][k].blue);
        end
      end
    end
    cnt_d = bsm3_pkg::CNT_W'(2'd3 - req_i.clo) * bsm3_pkg::CNT_W'(2'd3 - req_i.rlo);
  end

  // Divide by multiplying with the scaled reciprocal
  always_comb begin
    x_r = div_q.halve ? (sum_r_q >> 1) : sum_r_q;
    x_g = div_q.halve ? (sum_g_q >> 1) : sum_g_q;
    x_b = div_q.halve ? (sum_b_q >> 1) : sum_b_q;
    p_r = bsm3_pkg::PROD_W'(x_r) * bsm3_pkg::PROD_W'(div_q.m);
    p_g = bsm3_pkg::PROD_W'(x_g) * bsm3_pkg::PROD_W'(div_q.m);
    p_b = bsm3_pkg::PROD_W'(x_b) * bsm3_pkg::PROD_W'(div_q.m);
    res_d.red   = p_r[bsm3_pkg::RECIP_SHIFT +: bsm3_pkg::CHAN_W];
    res_d.green = p_g[bsm3_pkg::RECIP_SHIFT +: bsm3_pkg::CHAN_W];
    res_d.blue  = p_b[bsm3_pkg::RECIP_SHIFT +: bsm3_pkg::CHAN_W];
    res_d.row   = bsm3_pkg::OUT_POS_W'(b_req_q.row);
    res_d.col   = bsm3_pkg::OUT_POS_W'(b_req_q.col);
    res_d.last  = b_req_q.last;
  end

  // Advance stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (b_ready) begin
        b_valid_q <= req_valid_i;
      end
      if (c_ready) begin
        c_valid_q <= b_valid_q;
      end
    end
  end

  // Load stage payloads
  always_ff @(posedge clk_i) begin
    if (b_load) begin
      sum_r_q <= sum_r_d;
      sum_g_q <= sum_g_d;
      sum_b_q <= sum_b_d;
      div_q   <= bsm3_pkg::div_of(cnt_d);
      b_req_q <= req_i;
    end
    if (c_load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = c_valid_q;
  assign res_o       = res_q;

`ifndef NO_ASSERTIONS
  // A held result must not be overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q && out_stall_i |=> c_valid_q && $stable(res_q))
    else $error("stalled result changed");

  // A blocked sum stage keeps its request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q && !c_ready |=> b_valid_q && $stable(b_req_q))
    else $error("stalled request changed");

  // The red quotient never exceeds the width of one channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_valid_q |-> p_r[bsm3_pkg::PROD_W-1:bsm3_pkg::RECIP_SHIFT + bsm3_pkg::CHAN_W] == '0)
    else $error("red mean overflows a channel");
`endif

endmodule
